/* hw/rtl/catmull_rom_spline_eval_defines.svh */
// Assertion macros used by the spline evaluator RTL.
`ifndef CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/crs_pkg.sv */
`timescale 1ns / 1ps

package crs_pkg;

    // Table and number formats.
    localparam int MAX_POINTS  = 64;
    localparam int COORD_W     = 32;
    localparam int T_FRAC      = 16;
    localparam int T_W         = T_FRAC + 1;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int MIN_COUNT   = 4;
    localparam int COUNT_RESET = 4;

    // The table is split four ways so that four neighboring points read at once.
    localparam int N_BANKS     = 4;
    localparam int BANK_W      = 2;
    localparam int BANK_DEPTH  = MAX_POINTS / N_BANKS;

    // Datapath widths: the Horner terms grow by less than eight bits.
    localparam int ACC_W       = COORD_W + 8;
    localparam int Q_W         = ACC_W - T_FRAC;
    localparam int QT_W        = Q_W + T_W;
    localparam int RT_W        = T_FRAC + T_W;

    // Register stages from request acceptance to the output register.
    localparam int N_STAGES    = 9;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [T_W-1:0]            t_t;
    typedef logic [IDX_W-1:0]          index_t;
    typedef logic [CNT_W-1:0]          count_t;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } opcode_t;

    localparam t_t T_ONE = t_t'(1 << T_FRAC);
    localparam logic [RT_W:0] RND_HALF = (RT_W + 1)'(1 << (T_FRAC - 1));
    localparam acc_t SAT_HI = {{(ACC_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam acc_t SAT_LO = ~SAT_HI;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Stage enables and the curve parameter at each multiply stage.
    typedef struct packed {
        logic [N_STAGES:1] en;
        t_t                t2;
        t_t                t4;
        t_t                t6;
    } axis_ctl_t;

    // Partial products of one scaling by t, before rounding.
    typedef struct packed {
        logic            neg;
        logic [QT_W-1:0] qt;
        logic [RT_W-1:0] rt;
    } mulp_t;

endpackage

/* hw/rtl/crs_cmd_if.sv */
`timescale 1ns / 1ps

interface crs_cmd_if;
    logic              valid;
    logic              ready;
    crs_pkg::opcode_t  opcode;
    crs_pkg::index_t   index;
    crs_pkg::coord_t   x;
    crs_pkg::coord_t   y;
    crs_pkg::coord_t   z;
    crs_pkg::t_t       t;

    modport source (output valid, opcode, index, x, y, z, t, input ready);
    modport sink   (input valid, opcode, index, x, y, z, t, output ready);
endinterface

/* hw/rtl/crs_res_if.sv */
`timescale 1ns / 1ps

interface crs_res_if;
    logic            valid;
    logic            ready;
    crs_pkg::coord_t out_x;
    crs_pkg::coord_t out_y;
    crs_pkg::coord_t out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

/* hw/rtl/crs_axis.sv */
`timescale 1ns / 1ps

module crs_axis (
    input  logic                clk,
    input  crs_pkg::axis_ctl_t  ctl,
    input  crs_pkg::coord_t     p0,
    input  crs_pkg::coord_t     p1,
    input  crs_pkg::coord_t     p2,
    input  crs_pkg::coord_t     p3,
    output crs_pkg::coord_t     result
);

    // First half of acc * t / 2^F: split the magnitude and form both products.
    function automatic crs_pkg::mulp_t mul_split(input crs_pkg::acc_t acc,
                                                 input crs_pkg::t_t tv);
        crs_pkg::mulp_t                m;
        logic [crs_pkg::ACC_W-1:0]     mag;
        m.neg = acc[crs_pkg::ACC_W-1];
        mag   = m.neg ? -acc : acc;
        m.qt  = mag[crs_pkg::ACC_W-1:crs_pkg::T_FRAC] * tv;
        m.rt  = mag[crs_pkg::T_FRAC-1:0] * tv;
        return m;
    endfunction

    // Second half: round the fraction product to nearest, ties away from zero.
    function automatic crs_pkg::acc_t mul_join(input crs_pkg::mulp_t m);
        logic [crs_pkg::RT_W:0]        rsum;
        logic [crs_pkg::QT_W-1:0]      mag;
        crs_pkg::acc_t                 prod;
        rsum = {1'b0, m.rt} + crs_pkg::RND_HALF;
        mag  = m.qt + crs_pkg::QT_W'(rsum[crs_pkg::RT_W:crs_pkg::T_FRAC]);
        prod = crs_pkg::acc_t'(mag[crs_pkg::ACC_W-1:0]);
        return m.neg ? -prod : prod;
    endfunction

    // Halve with rounding away from zero, then clip to the coordinate range.
    function automatic crs_pkg::coord_t halve_sat(input crs_pkg::acc_t acc);
        logic [crs_pkg::ACC_W-1:0]     mag;
        logic [crs_pkg::ACC_W-1:0]     h;
        crs_pkg::acc_t                 v;
        crs_pkg::coord_t               r;
        mag = acc[crs_pkg::ACC_W-1] ? -acc : acc;
        h   = (mag + 1'b1) >> 1;
        v   = acc[crs_pkg::ACC_W-1] ? -crs_pkg::acc_t'(h) : crs_pkg::acc_t'(h);
        priority if (v > crs_pkg::SAT_HI)
        begin
            r = crs_pkg::SAT_HI[crs_pkg::COORD_W-1:0];
        end
        else if (v < crs_pkg::SAT_LO)
        begin
            r = crs_pkg::SAT_LO[crs_pkg::COORD_W-1:0];
        end
        else
        begin
            r = v[crs_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    crs_pkg::acc_t   e0, e1, e2, e3;
    crs_pkg::acc_t   a2_reg, b2_reg, c2_reg, d2_reg;
    crs_pkg::acc_t   a2_next, b2_next, c2_next, d2_next;
    crs_pkg::mulp_t  m3_reg, m3_next;
    crs_pkg::acc_t   a3_reg, b3_reg, d3_reg;
    crs_pkg::acc_t   acc4_reg, acc4_next, a4_reg, d4_reg;
    crs_pkg::mulp_t  m5_reg, m5_next;
    crs_pkg::acc_t   a5_reg, d5_reg;
    crs_pkg::acc_t   acc6_reg, acc6_next, d6_reg;
    crs_pkg::mulp_t  m7_reg, m7_next;
    crs_pkg::acc_t   d7_reg;
    crs_pkg::acc_t   acc8_reg, acc8_next;
    crs_pkg::coord_t res9_reg, res9_next;

    // Cubic coefficients from the four neighboring points.
    always_comb
    begin
        e0 = crs_pkg::acc_t'(p0);
        e1 = crs_pkg::acc_t'(p1);
        e2 = crs_pkg::acc_t'(p2);
        e3 = crs_pkg::acc_t'(p3);
        a2_next = e2 - e0;
        b2_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        c2_next = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
        d2_next = e1 <<< 1;
    end

    // Horner's rule: alternating multiply and round-and-add stages.
    always_comb
    begin
        m3_next   = mul_split(c2_reg, ctl.t2);
        acc4_next = b3_reg + mul_join(m3_reg);
        m5_next   = mul_split(acc4_reg, ctl.t4);
        acc6_next = a5_reg + mul_join(m5_reg);
        m7_next   = mul_split(acc6_reg, ctl.t6);
        acc8_next = d7_reg + mul_join(m7_reg);
        res9_next = halve_sat(acc8_reg);
    end

    // Stage registers, each held while its stage is stalled.
    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            a2_reg <= a2_next;
            b2_reg <= b2_next;
            c2_reg <= c2_next;
            d2_reg <= d2_next;
        end
        if (ctl.en[3])
        begin
            m3_reg <= m3_next;
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
            d3_reg <= d2_reg;
        end
        if (ctl.en[4])
        begin
            acc4_reg <= acc4_next;
            a4_reg   <= a3_reg;
            d4_reg   <= d3_reg;
        end
        if (ctl.en[5])
        begin
            m5_reg <= m5_next;
            a5_reg <= a4_reg;
            d5_reg <= d4_reg;
        end
        if (ctl.en[6])
        begin
            acc6_reg <= acc6_next;
            d6_reg   <= d5_reg;
        end
        if (ctl.en[7])
        begin
            m7_reg <= m7_next;
            d7_reg <= d6_reg;
        end
        if (ctl.en[8])
        begin
            acc8_reg <= acc8_next;
        end
        if (ctl.en[9])
        begin
            res9_reg <= res9_next;
        end
    end

    assign result = res9_reg;

endmodule

/* hw/rtl/catmull_rom_spline_eval.sv */
// Uniform Catmull-Rom evaluator over a table of 64 signed Q16.16 3D points.
// A write request stores one point and returns nothing; an evaluate request
// returns one curve point per request, with results in request order. The
// block takes one request per clock unless a result waiting to be taken
// holds it off. An evaluate request passes through nine register stages,
// the first loaded at the accepting edge: the table read, the coefficient
// stage, the three Horner multiply and round-and-add pairs and the output
// register. The table is banked four ways on the low index bits, so the
// four neighbors of a segment come out of four single-port banks at once.
// A write is visible to an evaluate accepted in the very next cycle. Table
// entries are undefined until written; there is no clearing pass after
// reset. point_count is clamped to 4..64, and a segment index outside
// 1..point_count-3 returns the nearest end point of the evaluable range
// unchanged.
`timescale 1ns / 1ps
`include "catmull_rom_spline_eval_defines.svh"

module catmull_rom_spline_eval (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  crs_pkg::count_t                 cfg_wdata,
    crs_cmd_if.sink                         cmd,
    crs_res_if.source                       res
);

    crs_pkg::count_t                  point_count_reg;
    logic [crs_pkg::N_STAGES:1]       en;
    logic [crs_pkg::N_STAGES:1]       v_reg, v_next;
    logic                             acc_req;
    logic                             wr_en;
    logic                             eval_acc;
    crs_pkg::point_t                  wr_point;
    crs_pkg::count_t                  cnt;
    crs_pkg::count_t                  last_seg;
    crs_pkg::index_t                  seg;
    crs_pkg::index_t                  j_base;
    logic                             clamp;
    logic                             clamp1_reg;
    crs_pkg::t_t                      t1_next;
    crs_pkg::t_t                      t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic [crs_pkg::BANK_W-1:0]       jlo1_reg;
    crs_pkg::point_t                  rd_reg [crs_pkg::N_BANKS];
    crs_pkg::point_t                  lane   [crs_pkg::N_BANKS];
    crs_pkg::axis_ctl_t               ctl;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= crs_pkg::count_t'(crs_pkg::COUNT_RESET);
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_wdata;
        end
    end

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        en[crs_pkg::N_STAGES] = !v_reg[crs_pkg::N_STAGES] || res.ready;
        for (int k = crs_pkg::N_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign cmd.ready = en[1];
    assign acc_req   = cmd.valid && en[1];
    assign wr_en     = acc_req && (cmd.opcode == crs_pkg::OP_WRITE);
    assign eval_acc  = acc_req && (cmd.opcode == crs_pkg::OP_EVAL);
    assign wr_point  = '{x: cmd.x, y: cmd.y, z: cmd.z};

    // Segment selection, with out-of-range indexes pinned to an end point.
    always_comb
    begin
        priority if (point_count_reg < crs_pkg::count_t'(crs_pkg::MIN_COUNT))
        begin
            cnt = crs_pkg::count_t'(crs_pkg::MIN_COUNT);
        end
        else if (point_count_reg > crs_pkg::count_t'(crs_pkg::MAX_POINTS))
        begin
            cnt = crs_pkg::count_t'(crs_pkg::MAX_POINTS);
        end
        else
        begin
            cnt = point_count_reg;
        end
        last_seg = cnt - crs_pkg::count_t'(2);
        priority if (crs_pkg::count_t'(cmd.index) >= last_seg)
        begin
            seg   = last_seg[crs_pkg::IDX_W-1:0];
            clamp = 1'b1;
        end
        else if (cmd.index == '0)
        begin
            seg   = crs_pkg::index_t'(1);
            clamp = 1'b1;
        end
        else
        begin
            seg   = cmd.index;
            clamp = 1'b0;
        end
        j_base = seg - crs_pkg::index_t'(1);
        // A pinned end point is the curve at t = 0, which is exactly P1.
        if (clamp)
        begin
            t1_next = '0;
        end
        else if (cmd.t > crs_pkg::T_ONE)
        begin
            t1_next = crs_pkg::T_ONE;
        end
        else
        begin
            t1_next = cmd.t;
        end
    end

    // Point table: four banks, one write or one registered read each per cycle.
    for (genvar b = 0; b < crs_pkg::N_BANKS; b++)
    begin : g_bank
        crs_pkg::point_t                 mem [crs_pkg::BANK_DEPTH];
        logic [crs_pkg::BANK_W-1:0]      off;
        crs_pkg::index_t                 addr;

        assign off  = crs_pkg::BANK_W'(b) - j_base[crs_pkg::BANK_W-1:0];
        assign addr = j_base + crs_pkg::index_t'(off);

        always_ff @(posedge clk)
        begin
            if (wr_en && (cmd.index[crs_pkg::BANK_W-1:0] == crs_pkg::BANK_W'(b)))
            begin
                mem[cmd.index[crs_pkg::IDX_W-1:crs_pkg::BANK_W]] <= wr_point;
            end
            if (eval_acc)
            begin
                rd_reg[b] <= mem[addr[crs_pkg::IDX_W-1:crs_pkg::BANK_W]];
            end
        end
    end

    // Rotate bank outputs into P0..P3 order. A pinned end point puts P1 on
    // every lane, so the cubic collapses to P1 and neighbors that may never
    // have been loaded stay out of the arithmetic.
    always_comb
    begin
        for (int l = 0; l < crs_pkg::N_BANKS; l++)
        begin
            if (clamp1_reg)
            begin
                lane[l] = rd_reg[jlo1_reg + crs_pkg::BANK_W'(1)];
            end
            else
            begin
                lane[l] = rd_reg[jlo1_reg + crs_pkg::BANK_W'(l)];
            end
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        v_next[1] = en[1] ? eval_acc : v_reg[1];
        for (int k = 2; k <= crs_pkg::N_STAGES; k++)
        begin
            v_next[k] = en[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Curve parameter and bank rotation carried alongside the data.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t1_reg     <= t1_next;
            jlo1_reg   <= j_base[crs_pkg::BANK_W-1:0];
            clamp1_reg <= clamp;
        end
        if (en[2])
        begin
            t2_reg <= t1_reg;
        end
        if (en[3])
        begin
            t3_reg <= t2_reg;
        end
        if (en[4])
        begin
            t4_reg <= t3_reg;
        end
        if (en[5])
        begin
            t5_reg <= t4_reg;
        end
        if (en[6])
        begin
            t6_reg <= t5_reg;
        end
    end

    assign ctl.en = en;
    assign ctl.t2 = t2_reg;
    assign ctl.t4 = t4_reg;
    assign ctl.t6 = t6_reg;

    // One arithmetic pipeline per axis.
    crs_axis u_axis_x (
        .clk    (clk),
        .ctl    (ctl),
        .p0     (lane[0].x),
        .p1     (lane[1].x),
        .p2     (lane[2].x),
        .p3     (lane[3].x),
        .result (res.out_x)
    );

    crs_axis u_axis_y (
        .clk    (clk),
        .ctl    (ctl),
        .p0     (lane[0].y),
        .p1     (lane[1].y),
        .p2     (lane[2].y),
        .p3     (lane[3].y),
        .result (res.out_y)
    );

    crs_axis u_axis_z (
        .clk    (clk),
        .ctl    (ctl),
        .p0     (lane[0].z),
        .p1     (lane[1].z),
        .p2     (lane[2].z),
        .p3     (lane[3].z),
        .result (res.out_z)
    );

    assign res.valid = v_reg[crs_pkg::N_STAGES];

    // Requests are only held off by a result that is waiting to be taken.
    `CRS_ASSERT_NOW(a_stall_from_output, clk, rst_n, !cmd.ready,
                    res.valid && !res.ready, "request stalled without a waiting result")
    // An accepted evaluate occupies the first stage.
    `CRS_ASSERT_NEXT(a_eval_enters, clk, rst_n, eval_acc, v_reg[1],
                     "evaluate request lost at entry")
    // A write never starts a result.
    `CRS_ASSERT_NEXT(a_write_no_result, clk, rst_n, wr_en, !v_reg[1],
                     "write request produced a result slot")
    // A pinned end point runs through the pipeline with t forced to zero.
    `CRS_ASSERT_NEXT(a_clamp_zero_t, clk, rst_n, eval_acc && clamp, t1_reg == '0,
                     "end point evaluated with nonzero t")

endmodule
